// ----- rtl/core/bpa_pkg.sv -----
package bpa_pkg;

  localparam int unsigned MaxPages  = 1024;
  localparam int unsigned PageW     = 10;
  localparam int unsigned LinkW     = 11;
  localparam int unsigned OrdW      = 4;
  localparam int unsigned TagW      = 32;
  localparam int unsigned NumOrders = 11;

  localparam logic [LinkW-1:0] NoPage = LinkW'(MaxPages);

  typedef enum logic [1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_RELEASE  = 2'd1,
    CMD_VALIDATE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_BAD_ORDER = 3'd1,
    STS_INVALID   = 3'd2,
    STS_NO_SPACE  = 3'd3,
    STS_CORRUPT   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PS_INTERIOR = 2'd0,
    PS_FREE     = 2'd1,
    PS_ALLOC    = 2'd2
  } pst_e;

  typedef enum logic [3:0] {
    ST_CLR, ST_BUILD, ST_IDLE, ST_A_SRCH, ST_A_CHK, ST_A_SPLIT, ST_R_CHK,
    ST_M_TOP, ST_M_BCHK, ST_W_STEP, ST_W_RD, ST_MG1, ST_MG2, ST_PUSH, ST_DONE
  } state_e;

  typedef struct packed {
    logic [LinkW-1:0] link;
    pst_e             st;
    logic [OrdW-1:0]  lvl;
    logic [TagW-1:0]  own;
    logic [TagW-1:0]  knd;
  } rec_t;

  function automatic logic [OrdW-1:0] log2f(input logic [LinkW-1:0] v);
    logic [OrdW-1:0] r;
    r = '0;
    for (int i = 0; i < LinkW; i++) begin
      if (v[i]) begin
        r = OrdW'(i);
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/bpa_req_if.sv -----
interface bpa_req_if import bpa_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [1:0]       cmd;
  logic [OrdW-1:0]  block_order;
  logic [PageW-1:0] start_page;
  logic [TagW-1:0]  owner_tag;
  logic [TagW-1:0]  kind_tag;

  modport source (output valid, cmd, block_order, start_page, owner_tag, kind_tag,
                  input ready);
  modport sink (input valid, cmd, block_order, start_page, owner_tag, kind_tag,
                output ready);
endinterface

// ----- rtl/core/bpa_rsp_if.sv -----
interface bpa_rsp_if import bpa_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [PageW-1:0] granted_page;
  logic             owner_matches;
  logic [LinkW-1:0] pages_free;

  modport source (output valid, status, granted_page, owner_matches, pages_free,
                  input ready);
  modport sink (input valid, status, granted_page, owner_matches, pages_free,
                output ready);
endinterface

// ----- rtl/core/bpa_rec_mem.sv -----
module bpa_rec_mem import bpa_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [PageW-1:0] waddr_i,
  input  rec_t             wdata_i,
  input  logic [PageW-1:0] raddr_i,
  output rec_t             rdata_o
);

  rec_t mem [MaxPages];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/core/buddy_page_allocator.sv -----
// Allocate searches the free lists from the requested order upward and splits the found block down.
// Release checks the record, then per merge walks the buddy's free list link by link and
// writes both records; validate only checks the record. One transaction is in work at a time.
// The record memory sets the pace: it has a single read port and a single write port.
// After reset and after each write of the page count register a clearing pass over
// all 1024 records and a rebuild of the free lists run before the first transaction is taken.
module buddy_page_allocator import bpa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LinkW-1:0] cfg_wdata_i,
  bpa_req_if.sink          req_i,
  bpa_rsp_if.source        rsp_o
);

  state_e            state_q, state_d;
  logic [LinkW-1:0]  pc_q, pc_d, free_q, free_d, idx_q, idx_d, left_q, left_d;
  logic [OrdW-1:0]   top_q, top_d, ord_q, ord_d, av_q, av_d;
  logic [LinkW-1:0]  heads_q [NumOrders];
  logic [LinkW-1:0]  heads_d [NumOrders];
  logic [PageW-1:0]  clr_q, clr_d, buddy_q, buddy_d;
  logic [LinkW-1:0]  cur_q, cur_d, prev_q, prev_d, steps_q, steps_d;
  cmd_e              cmd_q, cmd_d;
  logic [TagW-1:0]   own_q, own_d, knd_q, knd_d;
  rec_t              brec_q, brec_d, irec_q, irec_d, prec_q, prec_d;
  status_e           st_q, st_d, ost_q, ost_d;
  logic [PageW-1:0]  gr_q, gr_d, ogr_q, ogr_d;
  logic              mt_q, mt_d, omt_q, omt_d, ov_q, ov_d;
  logic [LinkW-1:0]  ofree_q, ofree_d;

  logic              mem_we;
  logic [PageW-1:0]  mem_waddr, mem_raddr;
  rec_t              mem_wdata, rd;

  logic [LinkW-1:0]  cfg_sat, hd, req_sz, sz, split_pg;
  logic [OrdW-1:0]   o, a;
  logic              blk_ok, tag_ok, lower;

  bpa_rec_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rd)
  );

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_sat = LinkW'(1);
    end else if (cfg_wdata_i > NoPage) begin
      cfg_sat = NoPage;
    end else begin
      cfg_sat = cfg_wdata_i;
    end
  end

  assign req_sz = LinkW'(1) << req_i.block_order;
  assign blk_ok = ({1'b0, req_i.start_page} < pc_q) &&
                  ((req_i.start_page & PageW'(req_sz - LinkW'(1))) == '0) &&
                  (req_sz <= pc_q - {1'b0, req_i.start_page});
  assign sz = LinkW'(1) << ord_q;
  assign hd = (av_q < OrdW'(NumOrders)) ? heads_q[av_q] : NoPage;
  assign o = log2f(left_q);
  assign a = av_q - OrdW'(1);
  assign split_pg = idx_q + (LinkW'(1) << a);
  assign tag_ok = (rd.st == PS_ALLOC) && (rd.lvl == ord_q) && (rd.own == own_q) &&
                  (rd.knd == knd_q);
  assign lower = buddy_q < idx_q[PageW-1:0];

  always_comb begin
    state_d = state_q;
    pc_d = pc_q; free_d = free_q; top_d = top_q; idx_d = idx_q; left_d = left_q;
    ord_d = ord_q; av_d = av_q; clr_d = clr_q; buddy_d = buddy_q;
    cur_d = cur_q; prev_d = prev_q; steps_d = steps_q; cmd_d = cmd_q;
    own_d = own_q; knd_d = knd_q; brec_d = brec_q; irec_d = irec_q; prec_d = prec_q;
    st_d = st_q; gr_d = gr_q; mt_d = mt_q;
    ost_d = ost_q; ogr_d = ogr_q; omt_d = omt_q; ofree_d = ofree_q;
    heads_d = heads_q;
    mem_we = 1'b0;
    mem_waddr = idx_q[PageW-1:0];
    mem_wdata = '0;
    mem_raddr = req_i.start_page;
    req_i.ready = 1'b0;
    ov_d = ov_q;
    if (ov_q && rsp_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      ST_CLR: begin
        mem_we = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '{link: NoPage, st: PS_INTERIOR, lvl: '0, own: '0, knd: '0};
        clr_d = clr_q + PageW'(1);
        if (clr_q == '1) begin
          idx_d = '0;
          left_d = pc_q;
          state_d = ST_BUILD;
        end
      end
      ST_BUILD: begin
        if (left_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          mem_we = 1'b1;
          mem_wdata = '{link: heads_q[o], st: PS_FREE, lvl: o, own: '0, knd: '0};
          heads_d[o] = idx_q;
          idx_d = idx_q + (LinkW'(1) << o);
          left_d = left_q - (LinkW'(1) << o);
        end
      end
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          cmd_d = cmd_e'(req_i.cmd);
          ord_d = req_i.block_order;
          own_d = req_i.owner_tag;
          knd_d = req_i.kind_tag;
          idx_d = {1'b0, req_i.start_page};
          av_d = req_i.block_order;
          st_d = STS_OK;
          gr_d = '0;
          mt_d = 1'b0;
          case (req_i.cmd)
            CMD_ALLOC: begin
              if (req_i.block_order > top_q) begin
                st_d = STS_BAD_ORDER;
                state_d = ST_DONE;
              end else begin
                state_d = ST_A_SRCH;
              end
            end
            CMD_RELEASE, CMD_VALIDATE: begin
              if (req_i.block_order > top_q) begin
                st_d = (req_i.cmd == CMD_RELEASE) ? STS_BAD_ORDER : STS_OK;
                state_d = ST_DONE;
              end else if (!blk_ok) begin
                st_d = (req_i.cmd == CMD_RELEASE) ? STS_INVALID : STS_OK;
                state_d = ST_DONE;
              end else begin
                state_d = ST_R_CHK;
              end
            end
            default: begin
              st_d = STS_BAD_ORDER;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_A_SRCH: begin
        mem_raddr = hd[PageW-1:0];
        if (av_q > top_q) begin
          st_d = STS_NO_SPACE;
          state_d = ST_DONE;
        end else if (hd == NoPage) begin
          av_d = av_q + OrdW'(1);
        end else if (hd >= pc_q) begin
          st_d = STS_CORRUPT;
          state_d = ST_DONE;
        end else begin
          idx_d = hd;
          state_d = ST_A_CHK;
        end
      end
      ST_A_CHK: begin
        if (rd.st != PS_FREE || rd.lvl != av_q) begin
          st_d = STS_CORRUPT;
          state_d = ST_DONE;
        end else begin
          heads_d[av_q] = rd.link;
          state_d = ST_A_SPLIT;
        end
      end
      ST_A_SPLIT: begin
        mem_we = 1'b1;
        if (av_q > ord_q) begin
          mem_waddr = split_pg[PageW-1:0];
          mem_wdata = '{link: heads_q[a], st: PS_FREE, lvl: a, own: '0, knd: '0};
          heads_d[a] = split_pg;
          av_d = a;
        end else begin
          mem_wdata = '{link: NoPage, st: PS_ALLOC, lvl: ord_q, own: own_q, knd: knd_q};
          free_d = free_q - sz;
          gr_d = idx_q[PageW-1:0];
          state_d = ST_DONE;
        end
      end
      ST_R_CHK: begin
        if (cmd_q == CMD_VALIDATE) begin
          mt_d = tag_ok;
          state_d = ST_DONE;
        end else if (!tag_ok) begin
          st_d = STS_INVALID;
          state_d = ST_DONE;
        end else begin
          free_d = free_q + sz;
          irec_d = rd;
          irec_d.st = PS_FREE;
          mem_we = 1'b1;
          mem_wdata = irec_d;
          state_d = ST_M_TOP;
        end
      end
      ST_M_TOP: begin
        buddy_d = idx_q[PageW-1:0] ^ (PageW'(1) << ord_q);
        mem_raddr = buddy_d;
        if (ord_q < top_q && {1'b0, buddy_d} < pc_q) begin
          state_d = ST_M_BCHK;
        end else begin
          state_d = ST_PUSH;
        end
      end
      ST_M_BCHK: begin
        if (rd.st != PS_FREE || rd.lvl != ord_q) begin
          state_d = ST_PUSH;
        end else begin
          brec_d = rd;
          cur_d = heads_q[ord_q];
          prev_d = NoPage;
          steps_d = '0;
          state_d = ST_W_STEP;
        end
      end
      ST_W_STEP: begin
        mem_raddr = cur_q[PageW-1:0];
        if (cur_q == NoPage || cur_q >= pc_q || steps_q > NoPage) begin
          st_d = STS_CORRUPT;
          state_d = ST_DONE;
        end else if (cur_q == {1'b0, buddy_q}) begin
          if (prev_q == NoPage) begin
            heads_d[ord_q] = brec_q.link;
          end else begin
            mem_we = 1'b1;
            mem_waddr = prev_q[PageW-1:0];
            mem_wdata = prec_q;
            mem_wdata.link = brec_q.link;
          end
          state_d = ST_MG1;
        end else begin
          state_d = ST_W_RD;
        end
      end
      ST_W_RD: begin
        prev_d = cur_q;
        prec_d = rd;
        cur_d = rd.link;
        steps_d = steps_q + LinkW'(1);
        state_d = ST_W_STEP;
      end
      ST_MG1: begin
        mem_we = 1'b1;
        mem_waddr = buddy_q;
        mem_wdata = brec_q;
        mem_wdata.st = lower ? PS_FREE : PS_INTERIOR;
        if (lower) begin
          mem_wdata.lvl = ord_q + OrdW'(1);
        end
        state_d = ST_MG2;
      end
      ST_MG2: begin
        mem_we = 1'b1;
        mem_wdata = irec_q;
        mem_wdata.st = lower ? PS_INTERIOR : PS_FREE;
        if (!lower) begin
          mem_wdata.lvl = ord_q + OrdW'(1);
        end
        if (lower) begin
          irec_d = brec_q;
          irec_d.st = PS_FREE;
          irec_d.lvl = ord_q + OrdW'(1);
          idx_d = {1'b0, buddy_q};
        end else begin
          irec_d = mem_wdata;
        end
        ord_d = ord_q + OrdW'(1);
        state_d = ST_M_TOP;
      end
      ST_PUSH: begin
        mem_we = 1'b1;
        mem_wdata = '{link: heads_q[ord_q], st: PS_FREE, lvl: ord_q, own: '0, knd: '0};
        heads_d[ord_q] = idx_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d = 1'b1;
          ost_d = st_q;
          ogr_d = gr_q;
          omt_d = mt_q;
          ofree_d = free_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      pc_d = cfg_sat;
      free_d = cfg_sat;
      top_d = log2f(cfg_sat);
      clr_d = '0;
      for (int i = 0; i < NumOrders; i++) begin
        heads_d[i] = NoPage;
      end
      state_d = ST_CLR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      pc_q <= NoPage;
      free_q <= NoPage;
      top_q <= log2f(NoPage);
      clr_q <= '0;
      ov_q <= 1'b0;
      for (int i = 0; i < NumOrders; i++) begin
        heads_q[i] <= NoPage;
      end
    end else begin
      state_q <= state_d;
      pc_q <= pc_d;
      free_q <= free_d;
      top_q <= top_d;
      clr_q <= clr_d;
      ov_q <= ov_d;
      heads_q <= heads_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    left_q <= left_d;
    ord_q <= ord_d;
    av_q <= av_d;
    buddy_q <= buddy_d;
    cur_q <= cur_d;
    prev_q <= prev_d;
    steps_q <= steps_d;
    cmd_q <= cmd_d;
    own_q <= own_d;
    knd_q <= knd_d;
    brec_q <= brec_d;
    irec_q <= irec_d;
    prec_q <= prec_d;
    st_q <= st_d;
    gr_q <= gr_d;
    mt_q <= mt_d;
    ost_q <= ost_d;
    ogr_q <= ogr_d;
    omt_q <= omt_d;
    ofree_q <= ofree_d;
  end

  assign rsp_o.valid = ov_q;
  assign rsp_o.status = ost_q;
  assign rsp_o.granted_page = ogr_q;
  assign rsp_o.owner_matches = omt_q;
  assign rsp_o.pages_free = ofree_q;

endmodule
